// File: src/assert_macros.svh
// Assertion helpers for the RTL, included by quaternion_to_axis_angle_top.
// ASSERT_CHK:   property must hold on every clock edge outside reset.
// ASSERT_NEVER: expression must never be true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: src/qtaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtaa_pkg
// Types, constants and the arctangent table for the quaternion to
// axis-angle pipeline.
// ----------------------------------------------------------------------------
package qtaa_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int ITERATIONS  = 16;
	localparam int THR_WIDTH   = 15;
	localparam int SQRT_STAGES = 16;
	localparam int QUO_WIDTH   = 17;
	localparam int DIV_STAGES  = QUO_WIDTH;
	localparam int CW          = 34;

	localparam logic [CW-1:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [CW-1:0] PI_Q30      = 34'd3373259426;
	localparam logic [15:0]   ANGLE_MAX   = 16'd51472;
	localparam logic [15:0]   AXIS_MAX    = 16'h7FFF;
	localparam logic [15:0]   AXIS_MIN    = 16'h8000;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 15'd1;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
		logic signed [DATA_WIDTH-1:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] axis_x;
		logic signed [DATA_WIDTH-1:0] axis_y;
		logic signed [DATA_WIDTH-1:0] axis_z;
		logic [DATA_WIDTH-1:0]        angle;
	} axis_angle_t;

	// one lane of the digit-by-digit square root
	typedef struct packed {
		logic [31:0] rad;
		logic [16:0] rem;
		logic [15:0] root;
	} sqrt_t;

	// one lane of the restoring divider
	typedef struct packed {
		logic [QUO_WIDTH-1:0] num;
		logic [16:0]          rem;
		logic [QUO_WIDTH-1:0] quo;
		logic [16:0]          den;
	} div_t;

	// CORDIC vector and angle accumulator, Q4.30
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cordic_t;

	function automatic logic [30:0] atan_q30(input logic [4:0] idx);
		logic [30:0] r;
		case (idx)
			5'd0:  r = 31'd843314856;
			5'd1:  r = 31'd497837829;
			5'd2:  r = 31'd263043836;
			5'd3:  r = 31'd133525158;
			5'd4:  r = 31'd67021686;
			5'd5:  r = 31'd33543515;
			5'd6:  r = 31'd16775850;
			5'd7:  r = 31'd8388437;
			5'd8:  r = 31'd4194282;
			5'd9:  r = 31'd2097149;
			5'd10: r = 31'd1048575;
			5'd11: r = 31'd524287;
			5'd12: r = 31'd262143;
			5'd13: r = 31'd131071;
			5'd14: r = 31'd65535;
			5'd15: r = 31'd32767;
			5'd16: r = 31'd16383;
			5'd17: r = 31'd8191;
			5'd18: r = 31'd4095;
			5'd19: r = 31'd2047;
			5'd20: r = 31'd1023;
			5'd21: r = 31'd511;
			5'd22: r = 31'd255;
			5'd23: r = 31'd127;
			5'd24: r = 31'd63;
			5'd25: r = 31'd31;
			5'd26: r = 31'd15;
			5'd27: r = 31'd8;
			5'd28: r = 31'd4;
			5'd29: r = 31'd2;
			5'd30: r = 31'd1;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

// File: src/qtaa_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtaa_sqrt_cell
// One root bit of a restoring integer square root: takes two radicand bits,
// tries the next root bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module qtaa_sqrt_cell (
	input  logic              clk,
	input  logic              en,
	input  qtaa_pkg::sqrt_t   d,
	output qtaa_pkg::sqrt_t   q
);

	logic [18:0] acc;
	logic [18:0] trial;
	logic [18:0] diff;
	qtaa_pkg::sqrt_t nxt;
	qtaa_pkg::sqrt_t st_q;

	// try subtracting 4*root+1 from the shifted remainder
	always_comb begin
		acc      = {d.rem, d.rad[31:30]};
		trial    = {1'b0, d.root, 2'b01};
		diff     = acc - trial;
		nxt.rad  = {d.rad[29:0], 2'b00};
		if (acc >= trial) begin
			nxt.rem  = diff[16:0];
			nxt.root = {d.root[14:0], 1'b1};
		end else begin
			nxt.rem  = acc[16:0];
			nxt.root = {d.root[14:0], 1'b0};
		end
	end

	// advance
	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign q = st_q;

endmodule

// File: src/qtaa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtaa_div_cell
// One quotient bit of a restoring divider: shifts in a numerator bit,
// subtracts the divisor where it fits and passes the state on.
// ----------------------------------------------------------------------------
module qtaa_div_cell (
	input  logic             clk,
	input  logic             en,
	input  qtaa_pkg::div_t   d,
	output qtaa_pkg::div_t   q
);

	logic [17:0] acc;
	logic [17:0] diff;
	qtaa_pkg::div_t nxt;
	qtaa_pkg::div_t st_q;

	// compare shifted remainder against the divisor
	always_comb begin
		acc     = {d.rem, d.num[qtaa_pkg::QUO_WIDTH-1]};
		diff    = acc - {1'b0, d.den};
		nxt.num = {d.num[qtaa_pkg::QUO_WIDTH-2:0], 1'b0};
		nxt.den = d.den;
		if (acc >= {1'b0, d.den}) begin
			nxt.rem = diff[16:0];
			nxt.quo = {d.quo[qtaa_pkg::QUO_WIDTH-2:0], 1'b1};
		end else begin
			nxt.rem = acc[16:0];
			nxt.quo = {d.quo[qtaa_pkg::QUO_WIDTH-2:0], 1'b0};
		end
	end

	// advance
	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign q = st_q;

endmodule

// File: src/qtaa_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtaa_cordic_cell
// One CORDIC vectoring micro-rotation with a fixed shift; drives y toward
// zero and accumulates the rotated angle.
// ----------------------------------------------------------------------------
module qtaa_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                en,
	input  qtaa_pkg::cordic_t   d,
	output qtaa_pkg::cordic_t   q
);

	localparam logic [4:0] IDX = STAGE[4:0];

	logic signed [qtaa_pkg::CW-1:0] sx;
	logic signed [qtaa_pkg::CW-1:0] sy;
	logic signed [qtaa_pkg::CW-1:0] step;
	qtaa_pkg::cordic_t nxt;
	qtaa_pkg::cordic_t st_q;

	// rotate against the sign of y
	always_comb begin
		sx   = d.x >>> STAGE;
		sy   = d.y >>> STAGE;
		step = {{(qtaa_pkg::CW-31){1'b0}}, qtaa_pkg::atan_q30(IDX)};
		if (!d.y[qtaa_pkg::CW-1] && (d.y != '0)) begin
			nxt.x = d.x + sy;
			nxt.y = d.y - sx;
			nxt.z = d.z + step;
		end else begin
			nxt.x = d.x - sy;
			nxt.y = d.y + sx;
			nxt.z = d.z - step;
		end
	end

	// advance
	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign q = st_q;

endmodule

// File: src/quaternion_to_axis_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_axis_angle_top
// Quaternion to axis-angle converter built as rows of arithmetic cells.
// ----------------------------------------------------------------------------
// Takes one quaternion beat per cycle while in_ready is high and returns one
// axis-angle beat for each, in order. From input accept to output valid a
// beat passes the square and sum registers, 16 square root cells (vector
// norm and sine of the half angle in parallel), the set-up register, 17
// divider cells (three axis lanes in parallel), ITERATIONS CORDIC cells,
// the result register and the output register. A skid register behind
// the output lets one more result finish while the consumer stalls; input
// ready drops only while that skid register is full. Vectors whose norm is
// zero or below zero_threshold give axis (0,0,1.0) and angle 0.
module quaternion_to_axis_angle_top #(
	parameter int ITERATIONS = qtaa_pkg::ITERATIONS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qtaa_pkg::THR_WIDTH-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  qtaa_pkg::quat_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output qtaa_pkg::axis_angle_t               out_data
);

`include "assert_macros.svh"

	localparam int NS = qtaa_pkg::SQRT_STAGES;
	localparam int ND = qtaa_pkg::DIV_STAGES;
	localparam int NC = ITERATIONS;
	localparam int QW = qtaa_pkg::QUO_WIDTH;
	localparam int CW = qtaa_pkg::CW;

	function automatic qtaa_pkg::div_t div_init(input logic signed [15:0] c,
		input logic [15:0] norm);
		logic [16:0] ce;
		logic [16:0] mag;
		logic [31:0] num;
		qtaa_pkg::div_t r;
		ce    = {c[15], c};
		mag   = c[15] ? (17'd0 - ce) : ce;
		num   = {mag[15:0], 16'd0} + {16'd0, norm};
		r.rem = {2'b00, num[31:17]};
		r.num = num[QW-1:0];
		r.quo = '0;
		r.den = {norm, 1'b0};
		return r;
	endfunction

	function automatic logic [15:0] sat_axis(input logic [QW-1:0] quo, input logic neg);
		logic [QW-1:0] nq;
		logic [15:0]   r;
		nq = '0 - quo;
		if (neg) begin
			r = (quo > {1'b0, qtaa_pkg::AXIS_MIN}) ? qtaa_pkg::AXIS_MIN : nq[15:0];
		end else begin
			r = (quo > {1'b0, qtaa_pkg::AXIS_MAX}) ? qtaa_pkg::AXIS_MAX : quo[15:0];
		end
		return r;
	endfunction

	logic en;
	logic [qtaa_pkg::THR_WIDTH-1:0] thr_q;

	// threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qtaa_pkg::THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	logic skid_valid_q;
	logic out_valid_q;
	assign en       = !skid_valid_q;
	assign in_ready = en;

	// ---------------- squares ----------------
	logic signed [31:0] px, py, pz, pw;
	logic        v_s1;
	logic [30:0] sqx_s1, sqy_s1, sqz_s1, sqw_s1;
	qtaa_pkg::quat_t quat_s1;

	assign px = in_data.quat_x * in_data.quat_x;
	assign py = in_data.quat_y * in_data.quat_y;
	assign pz = in_data.quat_z * in_data.quat_z;
	assign pw = in_data.quat_w * in_data.quat_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1  <= px[30:0];
			sqy_s1  <= py[30:0];
			sqz_s1  <= pz[30:0];
			sqw_s1  <= pw[30:0];
			quat_s1 <= in_data;
		end
	end

	// ---------------- sums ----------------
	logic        v_s2;
	logic [31:0] sum_s2;
	logic [30:0] vs_s2;
	qtaa_pkg::quat_t quat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
			vs_s2   <= 31'h4000_0000 - sqw_s1;
			quat_s2 <= quat_s1;
		end
	end

	// ---------------- square root row ----------------
	qtaa_pkg::sqrt_t n_st [0:NS];
	qtaa_pkg::sqrt_t s_st [0:NS];
	logic            sv   [0:NS];
	qtaa_pkg::quat_t sqp  [0:NS];

	assign n_st[0] = '{rad: sum_s2, rem: 17'd0, root: 16'd0};
	assign s_st[0] = '{rad: {1'b0, vs_s2}, rem: 17'd0, root: 16'd0};
	assign sv[0]   = v_s2;
	assign sqp[0]  = quat_s2;

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		qtaa_sqrt_cell u_norm (.clk(clk), .en(en), .d(n_st[k]), .q(n_st[k+1]));
		qtaa_sqrt_cell u_sin  (.clk(clk), .en(en), .d(s_st[k]), .q(s_st[k+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[k+1] <= 1'b0;
			end else if (en) begin
				sv[k+1] <= sv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqp[k+1] <= sqp[k];
			end
		end
	end

	// ---------------- set-up of divider and CORDIC ----------------
	logic [15:0] norm;
	logic [15:0] sine;
	logic signed [15:0] w;
	logic signed [CW-1:0] xw, ys;
	qtaa_pkg::cordic_t c_init;

	assign norm = n_st[NS].root;
	assign sine = s_st[NS].root;
	assign w    = sqp[NS].quat_w;
	assign xw   = {{3{w[15]}}, w, 15'd0};
	assign ys   = {3'b000, sine, 15'd0};

	// a negative w starts a quarter turn ahead
	always_comb begin
		if (w[15]) begin
			c_init.x = ys;
			c_init.y = -xw;
			c_init.z = qtaa_pkg::HALF_PI_Q30;
		end else begin
			c_init.x = xw;
			c_init.y = ys;
			c_init.z = '0;
		end
	end

	qtaa_pkg::div_t    dx_st [0:ND];
	qtaa_pkg::div_t    dy_st [0:ND];
	qtaa_pkg::div_t    dz_st [0:ND];
	qtaa_pkg::cordic_t dcp   [0:ND];
	logic [2:0]        dsg   [0:ND];
	logic              did   [0:ND];
	logic              dv    [0:ND];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= sv[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_st[0] <= div_init(sqp[NS].quat_x, norm);
			dy_st[0] <= div_init(sqp[NS].quat_y, norm);
			dz_st[0] <= div_init(sqp[NS].quat_z, norm);
			dcp[0]   <= c_init;
			dsg[0]   <= {sqp[NS].quat_x[15], sqp[NS].quat_y[15], sqp[NS].quat_z[15]};
			did[0]   <= (norm == 16'd0) || (norm < {1'b0, thr_q});
		end
	end

	// ---------------- divider row ----------------
	for (genvar k = 0; k < ND; k++) begin : g_div
		qtaa_div_cell u_dx (.clk(clk), .en(en), .d(dx_st[k]), .q(dx_st[k+1]));
		qtaa_div_cell u_dy (.clk(clk), .en(en), .d(dy_st[k]), .q(dy_st[k+1]));
		qtaa_div_cell u_dz (.clk(clk), .en(en), .d(dz_st[k]), .q(dz_st[k+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else if (en) begin
				dv[k+1] <= dv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dcp[k+1] <= dcp[k];
				dsg[k+1] <= dsg[k];
				did[k+1] <= did[k];
			end
		end
	end

	// ---------------- CORDIC row ----------------
	qtaa_pkg::cordic_t c_st [0:NC];
	logic [QW-1:0]     cqx  [0:NC];
	logic [QW-1:0]     cqy  [0:NC];
	logic [QW-1:0]     cqz  [0:NC];
	logic [2:0]        csg  [0:NC];
	logic              cid  [0:NC];
	logic              cv   [0:NC];

	assign c_st[0] = dcp[ND];
	assign cqx[0]  = dx_st[ND].quo;
	assign cqy[0]  = dy_st[ND].quo;
	assign cqz[0]  = dz_st[ND].quo;
	assign csg[0]  = dsg[ND];
	assign cid[0]  = did[ND];
	assign cv[0]   = dv[ND];

	for (genvar k = 0; k < NC; k++) begin : g_cordic
		qtaa_cordic_cell #(.STAGE(k)) u_rot (
			.clk(clk), .en(en), .d(c_st[k]), .q(c_st[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv[k+1] <= 1'b0;
			end else if (en) begin
				cv[k+1] <= cv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cqx[k+1] <= cqx[k];
				cqy[k+1] <= cqy[k];
				cqz[k+1] <= cqz[k];
				csg[k+1] <= csg[k];
				cid[k+1] <= cid[k];
			end
		end
	end

	// ---------------- result ----------------
	logic signed [CW-1:0] zf;
	logic [CW-1:0]        zc;
	logic [CW-1:0]        zr;
	logic [16:0]          ang;
	qtaa_pkg::axis_angle_t res;
	qtaa_pkg::axis_angle_t res_s3;
	logic                  v_s3;

	// clamp the angle to [0, pi], round to Q3.13 of twice the angle, and form the result (identity for small norms)
	always_comb begin
		zf = c_st[NC].z;
		if (zf[CW-1]) begin
			zc = '0;
		end else if (zf > qtaa_pkg::PI_Q30) begin
			zc = qtaa_pkg::PI_Q30;
		end else begin
			zc = zf;
		end
		zr  = zc + {{(CW-16){1'b0}}, 16'h8000};
		ang = zr[32:16];
		if (cid[NC]) begin
			res.axis_x = '0;
			res.axis_y = '0;
			res.axis_z = qtaa_pkg::AXIS_MAX;
			res.angle  = '0;
		end else begin
			res.axis_x = sat_axis(cqx[NC], csg[NC][2]);
			res.axis_y = sat_axis(cqy[NC], csg[NC][1]);
			res.axis_z = sat_axis(cqz[NC], csg[NC][0]);
			res.angle  = (ang > {1'b0, qtaa_pkg::ANGLE_MAX}) ? qtaa_pkg::ANGLE_MAX : ang[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= cv[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res;
		end
	end

	// ---------------- output register and skid ----------------
	qtaa_pkg::axis_angle_t out_q;
	qtaa_pkg::axis_angle_t skid_q;
	logic                  out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= v_s3;
		end else if (v_s3) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (out_free) begin
			out_q <= res_s3;
		end else begin
			skid_q <= res_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- checks ----------------
	`ASSERT_CHK(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`ASSERT_NEVER(a_no_take_when_full, clk, arst_n, skid_valid_q && in_ready)
	`ASSERT_CHK(a_angle_range, clk, arst_n, out_valid |-> (out_data.angle <= qtaa_pkg::ANGLE_MAX))
	`ASSERT_CHK(a_skid_drains, clk, arst_n, (skid_valid_q && out_ready) |=> !skid_valid_q)

endmodule

// File: tb/quaternion_to_axis_angle_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_axis_angle_top_tb
// Self-checking testbench for the quaternion to axis-angle pipeline.
// ----------------------------------------------------------------------------
// Drives quaternion beats through a table of corner cases and then random
// beats, under several zero_threshold settings, with random stalls on both
// sides. Beats without a written-in result are converted by an integer
// model of the norm, the axis division and the CORDIC arc cosine, and every
// output beat is compared field by field against the oldest pending result.
module quaternion_to_axis_angle_top_tb;

	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_BEATS  = 1020;

	// directed stimulus row: typed_exp marks rows whose result is written in
	typedef struct {
		qtaa_pkg::quat_t       quat;
		bit                    typed_exp;
		qtaa_pkg::axis_angle_t exp_val;
	} quat_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [qtaa_pkg::THR_WIDTH-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	qtaa_pkg::quat_t                in_data;
	logic                           out_valid;
	logic                           out_ready;
	qtaa_pkg::axis_angle_t          out_data;

	qtaa_pkg::axis_angle_t pending_q[$];
	longint      threshold_mdl;
	int          err_cnt;
	int          beat_cnt;
	int          ident_cnt;
	int          sat_cnt;
	int          idle_cycles;
	bit          quiet;

	longint atan_tbl[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767};

	quaternion_to_axis_angle_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor square root, digit by digit
	function automatic longint floor_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// rounded, saturated quotient c / norm in Q1.15
	function automatic logic [15:0] unit_component(input longint c, input longint norm);
		longint mag;
		longint q;
		longint r;
		mag = (c < 0) ? -c : c;
		q = (mag * 65536 + norm) / (2 * norm);
		if (c < 0)
			r = (q > 32768) ? -32768 : -q;
		else
			r = (q > 32767) ? 32767 : q;
		return r[15:0];
	endfunction

	// 2*acos(w) via CORDIC vectoring, Q3.13
	function automatic logic [15:0] rotation_angle(input longint w);
		longint s;
		longint x;
		longint y;
		longint z;
		longint nx;
		longint t;
		longint a;
		s = floor_sqrt(longint'(64'd1 << 30) - w * w);
		x = w * 32768;
		y = s * 32768;
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = qtaa_pkg::HALF_PI_Q30;
		end
		for (int i = 0; i < qtaa_pkg::ITERATIONS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_tbl[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_tbl[i];
			end
			x = nx;
		end
		if (z < 0)
			z = 0;
		if (z > longint'(qtaa_pkg::PI_Q30))
			z = qtaa_pkg::PI_Q30;
		a = (z * 2 + 65536) >>> 17;
		if (a > 51472)
			a = 51472;
		return a[15:0];
	endfunction

	function automatic qtaa_pkg::axis_angle_t convert_quat(input qtaa_pkg::quat_t q);
		qtaa_pkg::axis_angle_t r;
		longint qx;
		longint qy;
		longint qz;
		longint norm;
		qx = q.quat_x;
		qy = q.quat_y;
		qz = q.quat_z;
		norm = floor_sqrt(qx * qx + qy * qy + qz * qz);
		if (norm == 0 || norm < threshold_mdl) begin
			r = '{16'sd0, 16'sd0, qtaa_pkg::AXIS_MAX, 16'd0};
		end else begin
			r.axis_x = unit_component(qx, norm);
			r.axis_y = unit_component(qy, norm);
			r.axis_z = unit_component(qz, norm);
			r.angle  = rotation_angle(q.quat_w);
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_component();
		case ($urandom_range(0, 5))
			0: return 16'($signed($urandom_range(0, 8)) - 4);
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'($signed($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// send one quaternion beat and log its expected conversion
	task automatic send_quat(input qtaa_pkg::quat_t q, input bit typed_exp,
		input qtaa_pkg::axis_angle_t typed_val);
		qtaa_pkg::axis_angle_t exp_val;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = q;
		exp_val  = typed_exp ? typed_val : convert_quat(q);
		if (exp_val.angle == 0 && exp_val.axis_z == qtaa_pkg::AXIS_MAX && exp_val.axis_x == 0)
			ident_cnt++;
		if (exp_val.axis_x == qtaa_pkg::AXIS_MAX || exp_val.axis_x == qtaa_pkg::AXIS_MIN)
			sat_cnt++;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(exp_val);
		beat_cnt++;
		@(negedge clk);
	endtask

	// write zero_threshold once the pipeline has drained
	task automatic write_threshold(input logic [qtaa_pkg::THR_WIDTH-1:0] thr);
		in_valid = 1'b0;
		wait (pending_q.size() == 0);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = thr;
		do @(posedge clk); while (!cfg_ready);
		threshold_mdl = thr;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// compare each output beat with the oldest pending conversion
	always @(posedge clk) begin
		qtaa_pkg::axis_angle_t exp_val;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected output beat %h", $time, out_data);
				err_cnt++;
			end else begin
				exp_val = pending_q.pop_front();
				if (out_data.axis_x !== exp_val.axis_x)
					$display("%0t: axis_x expected %0d actual %0d", $time,
						exp_val.axis_x, out_data.axis_x);
				if (out_data.axis_y !== exp_val.axis_y)
					$display("%0t: axis_y expected %0d actual %0d", $time,
						exp_val.axis_y, out_data.axis_y);
				if (out_data.axis_z !== exp_val.axis_z)
					$display("%0t: axis_z expected %0d actual %0d", $time,
						exp_val.axis_z, out_data.axis_z);
				if (out_data.angle !== exp_val.angle)
					$display("%0t: angle expected %0d actual %0d", $time,
						exp_val.angle, out_data.angle);
				if (out_data !== exp_val)
					err_cnt++;
			end
		end
	end

	// stall the output side in random bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// end the run when no beat moves for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("quaternion_to_axis_angle_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		quat_row_t             rows[$];
		qtaa_pkg::axis_angle_t ident;
		qtaa_pkg::quat_t       q;
		int                    thr_list[5];
		ident = '{16'sd0, 16'sd0, qtaa_pkg::AXIS_MAX, 16'd0};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		err_cnt = 0;
		beat_cnt = 0;
		ident_cnt = 0;
		sat_cnt = 0;
		quiet = 1'b0;
		threshold_mdl = qtaa_pkg::THR_RESET;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner cases: zero vector, extremes, short axis, w at both ends
		rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, ident});
		rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, -16'sd32768}, 1, ident});
		rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767}, 1, ident});
		rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0, 16'sd0}, 0, ident});
		rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 0, ident});
		rows.push_back('{'{16'sd0, 16'sd32767, 16'sd0, 16'sd32767}, 0, ident});
		rows.push_back('{'{16'sd0, -16'sd32768, 16'sd0, -16'sd32768}, 0, ident});
		rows.push_back('{'{16'sd0, 16'sd0, 16'sd32767, -16'sd1}, 0, ident});
		rows.push_back('{'{16'sd0, 16'sd0, -16'sd32768, 16'sd1}, 0, ident});
		rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 0, ident});
		rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 0, ident});
		rows.push_back('{'{16'sd1, 16'sd1, 16'sd0, 16'sd32767}, 0, ident});
		rows.push_back('{'{-16'sd1, -16'sd1, -16'sd1, -16'sd32768}, 0, ident});
		rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sd23170}, 0, ident});
		rows.push_back('{'{16'sd3, -16'sd4, 16'sd0, -16'sd23170}, 0, ident});
		rows.push_back('{'{16'sd12000, -16'sd9000, 16'sd5000, 16'sd16384}, 0, ident});
		rows.push_back('{'{-16'sd700, 16'sd300, -16'sd25000, -16'sd16384}, 0, ident});
		foreach (rows[i])
			send_quat(rows[i].quat, rows[i].typed_exp, rows[i].exp_val);

		// random beats under several thresholds, extremes included
		thr_list = '{0, 32767, 40, $urandom_range(2, 32766), 1};
		foreach (thr_list[p]) begin
			write_threshold(thr_list[p][qtaa_pkg::THR_WIDTH-1:0]);
			if (thr_list[p] == 0) begin
				// zero norm must still give the identity
				q = '0;
				send_quat(q, 1, ident);
			end
			for (int i = 0; i < RANDOM_BEATS / 5; i++) begin
				if (p == 4 && i >= RANDOM_BEATS / 5 - 60)
					quiet = 1'b1;
				q.quat_x = rand_component();
				q.quat_y = rand_component();
				q.quat_z = rand_component();
				q.quat_w = ($urandom_range(0, 4) == 0) ? rand_component() : 16'($urandom);
				send_quat(q, 0, ident);
			end
		end
		in_valid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (60) @(negedge clk);
		$display("covered %0d quaternions over 6 threshold settings, %0d identity, %0d x saturated",
			beat_cnt, ident_cnt, sat_cnt);
		if (err_cnt == 0 && pending_q.size() == 0) begin
			$display("quaternion_to_axis_angle_top verification clean");
		end else begin
			$display("quaternion_to_axis_angle_top verification failed");
		end
		$finish;
	end

endmodule
